@@ src/mrbu_pkg.sv @@
// ----------------------------------------------------------------------------
// mrbu_pkg
// Shared types and constants of the raw byte unpacker.
// ----------------------------------------------------------------------------
package mrbu_pkg;

  localparam int BYTE_W        = 8;
  localparam int PIXEL_W       = 16;
  localparam int DIM_W         = 14;
  localparam int MAX_DIMENSION = 8192;
  localparam int MAX_PIXELS    = 4;
  localparam int NPIX_W        = $clog2(MAX_PIXELS + 1);
  localparam int PIX_IDX_W     = $clog2(MAX_PIXELS);
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = DIM_W;

  // Largest dimension a register can actually express after clamping.
  localparam int EFF_DIM = (MAX_DIMENSION < (2 ** DIM_W - 1)) ? MAX_DIMENSION
                                                               : (2 ** DIM_W - 1);
  localparam int COUNT_W = $clog2(EFF_DIM * EFF_DIM);
  localparam int PROD_W  = 2 * DIM_W;

  localparam int RESET_WIDTH  = 1920;
  localparam int RESET_HEIGHT = 1080;

  localparam logic [7:0] RAW10_LOW_MASK = 8'h03;
  localparam logic [7:0] RAW12_LOW_MASK = 8'h0f;

  typedef enum logic [1:0] {
    MODE_RAW10   = 2'd0,
    MODE_RAW12   = 2'd1,
    MODE_RAW16   = 2'd2,
    MODE_DISCARD = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PACKING_MODE = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_e;

  typedef struct packed {
    mode_e              mode;
    logic               mode_wr;
    logic [COUNT_W-1:0] last_index;
  } cfg_t;

  typedef struct packed {
    logic                               push;
    logic [NPIX_W-1:0]                  npix;
    logic [MAX_PIXELS-1:0][PIXEL_W-1:0] pix;
  } group_t;

  // Zero maps to one, anything above the maximum maps to the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > MAX_DIMENSION) begin
      r = DIM_W'(MAX_DIMENSION);
    end
    return r;
  endfunction

endpackage

@@ src/mrbu_byte_if.sv @@
// ----------------------------------------------------------------------------
// mrbu_byte_if
// Byte stream channel carrying packed sensor bytes.
// ----------------------------------------------------------------------------
interface mrbu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;

  modport source (output valid, output packed_byte, input ready);
  modport sink (input valid, input packed_byte, output ready);
endinterface

@@ src/mrbu_pixel_if.sv @@
// ----------------------------------------------------------------------------
// mrbu_pixel_if
// Pixel stream channel carrying unpacked pixels and their markers.
// ----------------------------------------------------------------------------
interface mrbu_pixel_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_value;
  logic        last_of_run;
  logic        end_of_frame;

  modport source (output valid, output pixel_value, output last_of_run,
                  output end_of_frame, input ready);
  modport sink (input valid, input pixel_value, input last_of_run,
                input end_of_frame, output ready);
endinterface

@@ src/mrbu_cfg.sv @@
// ----------------------------------------------------------------------------
// mrbu_cfg
// Configuration registers and the registered index of the last frame pixel.
// ----------------------------------------------------------------------------
module mrbu_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mrbu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mrbu_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output mrbu_pkg::cfg_t                 cfg_o
);
  import mrbu_pkg::*;

  mode_e              mode_q;
  logic [DIM_W-1:0]   width_q, height_q;
  logic [COUNT_W-1:0] last_index_q;
  logic               mode_wr;
  logic [PROD_W-1:0]  area;

  assign mode_wr = cfg_we_i && (reg_idx_e'(cfg_idx_i) == REG_PACKING_MODE);
  assign area    = PROD_W'(clamp_dim(width_q)) * PROD_W'(clamp_dim(height_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_RAW10;
      width_q      <= DIM_W'(RESET_WIDTH);
      height_q     <= DIM_W'(RESET_HEIGHT);
      last_index_q <= COUNT_W'(RESET_WIDTH * RESET_HEIGHT - 1);
    end else begin
      last_index_q <= COUNT_W'(area - PROD_W'(1));
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_PACKING_MODE: mode_q   <= mode_e'(cfg_data_i[1:0]);
          REG_FRAME_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
          REG_FRAME_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign cfg_o.mode       = mode_q;
  assign cfg_o.mode_wr    = mode_wr;
  assign cfg_o.last_index = last_index_q;

endmodule

@@ src/mrbu_assembler.sv @@
// ----------------------------------------------------------------------------
// mrbu_assembler
// Collects the bytes of one packing group and forms its pixels.
// ----------------------------------------------------------------------------
module mrbu_assembler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mrbu_pkg::cfg_t              cfg_i,
  input  logic                        valid_i,
  input  logic [mrbu_pkg::BYTE_W-1:0] byte_i,
  output logic                        ready_o,
  input  logic                        busy_i,
  output mrbu_pkg::group_t            group_o
);
  import mrbu_pkg::*;

  logic [2:0]        pos_q, pos_d;
  logic [BYTE_W-1:0] held_q [MAX_PIXELS];
  logic [2:0]        group_len;
  logic              completing, accept, active;

  always_comb begin
    case (cfg_i.mode)
      MODE_RAW10: group_len = 3'd5;
      MODE_RAW12: group_len = 3'd3;
      MODE_RAW16: group_len = 3'd2;
      default:    group_len = 3'd0;
    endcase
  end

  assign active     = (group_len != 3'd0);
  assign completing = active && (pos_q == group_len - 3'd1);
  // The closing byte of a group waits until the group register is free.
  assign ready_o    = !(completing && busy_i);
  assign accept     = valid_i && ready_o;

  always_comb begin
    pos_d = pos_q;
    if (cfg_i.mode_wr) begin
      pos_d = '0;
    end else if (accept && active) begin
      pos_d = completing ? 3'd0 : pos_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && active && !completing) begin
      held_q[pos_q[PIX_IDX_W-1:0]] <= byte_i;
    end
  end

  always_comb begin
    group_o.push = accept && completing;
    group_o.pix  = '0;
    group_o.npix = '0;
    case (cfg_i.mode)
      MODE_RAW10: begin
        for (int k = 0; k < MAX_PIXELS; k++) begin
          group_o.pix[k] = {6'b0, held_q[k],
                            2'((byte_i >> (6 - 2 * k)) & RAW10_LOW_MASK)};
        end
        group_o.npix = NPIX_W'(4);
      end
      MODE_RAW12: begin
        group_o.pix[0] = {4'b0, held_q[0], 4'((byte_i >> 4) & RAW12_LOW_MASK)};
        group_o.pix[1] = {4'b0, held_q[1], 4'(byte_i & RAW12_LOW_MASK)};
        group_o.npix   = NPIX_W'(2);
      end
      MODE_RAW16: begin
        group_o.pix[0] = {byte_i, held_q[0]};
        group_o.npix   = NPIX_W'(1);
      end
      default: ;
    endcase
  end

endmodule

@@ src/mrbu_drain.sv @@
// ----------------------------------------------------------------------------
// mrbu_drain
// Holds one pixel group, sends its pixels one a cycle while the sink is ready and counts the frame.
// ----------------------------------------------------------------------------
module mrbu_drain (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [mrbu_pkg::COUNT_W-1:0] last_index_i,
  input  mrbu_pkg::group_t             group_i,
  output logic                         busy_o,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [mrbu_pkg::PIXEL_W-1:0] pixel_o,
  output logic                         last_o,
  output logic                         eof_o
);
  import mrbu_pkg::*;

  logic                               g_valid_q;
  logic [MAX_PIXELS-1:0][PIXEL_W-1:0] g_pix_q;
  logic [NPIX_W-1:0]                  g_n_q;
  logic [PIX_IDX_W-1:0]               g_idx_q;
  logic                               o_valid_q, o_last_q, o_eof_q;
  logic [PIXEL_W-1:0]                 o_pix_q;
  logic [COUNT_W-1:0]                 count_q;
  logic                               move, eof, last;

  assign move = g_valid_q && (!o_valid_q || ready_i);
  assign eof  = (count_q >= last_index_i);
  assign last = eof || ((NPIX_W'(g_idx_q) + NPIX_W'(1)) == g_n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_valid_q <= 1'b0;
      g_idx_q   <= '0;
      o_valid_q <= 1'b0;
      count_q   <= '0;
    end else begin
      if (group_i.push) begin
        g_valid_q <= 1'b1;
        g_idx_q   <= '0;
      end else if (move) begin
        if (last) begin
          g_valid_q <= 1'b0;
        end
        g_idx_q <= g_idx_q + PIX_IDX_W'(1);
      end
      if (move) begin
        o_valid_q <= 1'b1;
        count_q   <= eof ? '0 : count_q + COUNT_W'(1);
      end else if (ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (group_i.push) begin
      g_pix_q <= group_i.pix;
      g_n_q   <= group_i.npix;
    end
    if (move) begin
      o_pix_q  <= g_pix_q[g_idx_q];
      o_last_q <= last;
      o_eof_q  <= eof;
    end
  end

  assign busy_o  = g_valid_q;
  assign valid_o = o_valid_q;
  assign pixel_o = o_pix_q;
  assign last_o  = o_last_q;
  assign eof_o   = o_eof_q;

  a_push_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    group_i.push |-> !g_valid_q)
    else $error("group pushed while the group register was still occupied");

  a_eof_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && o_eof_q) |-> o_last_q)
    else $error("end-of-frame pixel not marked as last of its run");

  a_count_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && eof) |=> (count_q == '0) && !g_valid_q)
    else $error("frame end did not restart the count and drop the group");

endmodule

@@ src/mipi_raw_byte_unpacker_unit.sv @@
// ----------------------------------------------------------------------------
// mipi_raw_byte_unpacker_unit
// Unpacks RAW10, RAW12 and RAW16 sensor byte streams into aligned pixels.
// ----------------------------------------------------------------------------
// The unit takes one packed byte per clock and hands out one right-aligned
// pixel per clock while the sink is ready. Bytes of a group are gathered
// in a small holding store; the byte that closes a group forms all its
// pixels at once and loads them into a group register, from which they
// leave one a cycle, as the sink takes them, through an output register. A
// closing byte is held off only while the previous group register still
// has pixels waiting, which under a steady sink never happens, as every
// format has more bytes per group than pixels. The pixel counter compares
// against a registered width times height product, so a dimension write
// takes effect once the product register has caught up; the end-of-frame pixel
// also ends its run, and any remaining pixels of that group are dropped. A
// mode write abandons any partially gathered group but keeps the frame count.
// ----------------------------------------------------------------------------
module mipi_raw_byte_unpacker_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mrbu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mrbu_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mrbu_byte_if.sink                       byte_i,
  mrbu_pixel_if.source                    pixel_o
);
  import mrbu_pkg::*;

  cfg_t   cfg;
  group_t group;
  logic   busy;

  // Register file; also derives the index of the final pixel in a frame.
  mrbu_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Gathers bytes and builds the pixels of a completed group.
  mrbu_assembler u_assembler (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (byte_i.valid),
    .byte_i  (byte_i.packed_byte),
    .ready_o (byte_i.ready),
    .busy_i  (busy),
    .group_o (group)
  );

  // Sends pixels one per transaction and tracks the frame position.
  mrbu_drain u_drain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .last_index_i (cfg.last_index),
    .group_i      (group),
    .busy_o       (busy),
    .valid_o      (pixel_o.valid),
    .ready_i      (pixel_o.ready),
    .pixel_o      (pixel_o.pixel_value),
    .last_o       (pixel_o.last_of_run),
    .eof_o        (pixel_o.end_of_frame)
  );

endmodule

@@ tb/sv/tb_mipi_raw_byte_unpacker_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mipi_raw_byte_unpacker_unit
// Self-checking bench for the raw byte unpacker. A directed table and a run
// of randomised phases feed packed bytes in every packing mode and at many
// frame sizes. A local model of the unpacker predicts each pixel, and every
// pixel transaction is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_mipi_raw_byte_unpacker_unit;
  import mrbu_pkg::*;

  localparam int MAX_IDLE      = 12;       // longest gap or stall per transaction
  localparam int SETTLE_CYCLES = 8;        // settle time after the last predicted pixel is seen
  localparam int RANDOM_ITEMS  = 70;       // non-discarded bytes in the random part
  localparam int TIMEOUT_NS    = 5000000;  // far above the slowest legal run

  // One pixel as it should leave the unit.
  typedef struct packed {
    logic [PIXEL_W-1:0] value;
    logic               last;
    logic               eof;
  } pixel_t;

  typedef enum logic {
    ROW_CFG,
    ROW_BYTE
  } row_kind_e;

  // A row of the directed table is either a register write or one byte.
  // Where n_typed is non-zero the pixels are given by hand and the last of
  // them closes the run; otherwise the local model supplies the pixels.
  typedef struct {
    row_kind_e        kind;
    reg_idx_e         cfg_sel;
    logic [DIM_W-1:0] value;
    int               n_typed;
    logic [15:0]      typed_pix [4];
    logic             typed_eof;
  } stim_row_t;

  localparam int N_DIRECTED = 40;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  mrbu_byte_if  byte_ch ();
  mrbu_pixel_if pixel_ch ();

  mipi_raw_byte_unpacker_unit uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .byte_i    (byte_ch),
    .pixel_o   (pixel_ch)
  );

  // Local copy of the unpacker state and its registers.
  mode_e            cur_mode;
  logic [DIM_W-1:0] cur_width;
  logic [DIM_W-1:0] cur_height;
  logic [2:0]       grp_pos;
  logic [7:0]       grp_bytes [4];
  longint           frame_pix_count;

  // Pixels predicted but not yet seen on the output, oldest first.
  pixel_t pixels_due [$];

  // Whether each side inserts idle cycles in the current phase.
  bit src_gaps_on;
  bit sink_stalls_on;

  int mismatches;
  int bytes_fed;
  int pixels_seen;
  int frame_ends;
  int settings_used;

  stim_row_t directed_rows [N_DIRECTED] = '{
    // Straight after reset the unit is in RAW10 with a full HD frame.
    '{ROW_BYTE, REG_UNUSED, 14'h000, 0, '{default: 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h0ff, 0, '{default: 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h000, 0, '{default: 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h0ff, 0, '{default: 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h0e4, 4, '{16'h003, 16'h3fe, 16'h001, 16'h3fc}, 1'b0},
    // RAW12 with both nibbles of the shared byte distinct.
    '{ROW_CFG, REG_PACKING_MODE, 14'(MODE_RAW12), 0, '{default: 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h0ff, 0, '{default: 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h000, 0, '{default: 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h05a, 2, '{16'hff5, 16'h00a, 16'h0, 16'h0}, 1'b0},
    // RAW16, low byte first.
    '{ROW_CFG, REG_PACKING_MODE, 14'(MODE_RAW16), 0, '{default: 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h000, 0, '{default: 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h0ff, 1, '{16'hff00, 16'h0, 16'h0, 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h0ff, 0, '{default: 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h000, 1, '{16'h00ff, 16'h0, 16'h0, 16'h0}, 1'b0},
    // Discard mode swallows bytes without a pixel.
    '{ROW_CFG, REG_PACKING_MODE, 14'(MODE_DISCARD), 0, '{default: 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h0aa, 0, '{default: 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h055, 0, '{default: 16'h0}, 1'b0},
    // Zero dimensions act as a one-pixel frame, so the first pixel of the
    // RAW10 group ends the frame and the other three are dropped.
    '{ROW_CFG, REG_FRAME_WIDTH, 14'd0, 0, '{default: 16'h0}, 1'b0},
    '{ROW_CFG, REG_FRAME_HEIGHT, 14'd0, 0, '{default: 16'h0}, 1'b0},
    '{ROW_CFG, REG_PACKING_MODE, 14'(MODE_RAW10), 0, '{default: 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h080, 0, '{default: 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h011, 0, '{default: 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h022, 0, '{default: 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h033, 0, '{default: 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h0ff, 1, '{16'h203, 16'h0, 16'h0, 16'h0}, 1'b1},
    // A mode write part way through a group throws the held byte away.
    '{ROW_CFG, REG_PACKING_MODE, 14'(MODE_RAW12), 0, '{default: 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h012, 0, '{default: 16'h0}, 1'b0},
    '{ROW_CFG, REG_PACKING_MODE, 14'(MODE_RAW16), 0, '{default: 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h034, 0, '{default: 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h056, 1, '{16'h5634, 16'h0, 16'h0, 16'h0}, 1'b1},
    // Dimensions above the maximum are clamped to the maximum.
    '{ROW_CFG, REG_FRAME_WIDTH, 14'h3fff, 0, '{default: 16'h0}, 1'b0},
    '{ROW_CFG, REG_FRAME_HEIGHT, 14'h3fff, 0, '{default: 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h001, 0, '{default: 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h002, 0, '{default: 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h003, 0, '{default: 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h004, 0, '{default: 16'h0}, 1'b0},
    // Shrinking the frame below the current count ends it on the next pixel.
    '{ROW_CFG, REG_FRAME_WIDTH, 14'd2, 0, '{default: 16'h0}, 1'b0},
    '{ROW_CFG, REG_FRAME_HEIGHT, 14'd1, 0, '{default: 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h005, 0, '{default: 16'h0}, 1'b0},
    '{ROW_BYTE, REG_UNUSED, 14'h006, 1, '{16'h0605, 16'h0, 16'h0, 16'h0}, 1'b1}
  };

  // 10 ns clock.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Bytes that make up one group in the given mode; discard counts as one.
  function automatic int group_bytes(input mode_e m);
    case (m)
      MODE_RAW10: return 5;
      MODE_RAW12: return 3;
      MODE_RAW16: return 2;
      default:    return 1;
    endcase
  endfunction

  // A zero dimension counts as one, anything above the maximum as the maximum.
  function automatic longint effective_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (longint'(v) > MAX_DIMENSION) return MAX_DIMENSION;
    return longint'(v);
  endfunction

  // Takes one accepted byte into the local state and returns the pixels it
  // releases. Only the byte that closes a group releases anything; all the
  // pixels of the group leave together, cut short at the end of a frame.
  function automatic int unpack_group(input logic [7:0] b, output pixel_t pix [4]);
    int          glen;
    int          npix;
    int          n;
    logic [15:0] val [4];
    longint      last_idx;
    logic        eof;
    pix = '{default: '0};
    val = '{default: '0};
    npix = 0;
    n = 0;
    if (cur_mode == MODE_DISCARD) return 0;
    glen = group_bytes(cur_mode);
    if (int'(grp_pos) + 1 < glen) begin
      grp_bytes[grp_pos[1:0]] = b;
      grp_pos = grp_pos + 3'd1;
      return 0;
    end
    grp_pos = '0;
    case (cur_mode)
      MODE_RAW10: begin
        // The fifth byte carries the two low bits of each pixel, pixel 0 in
        // its top two bits.
        for (int k = 0; k < 4; k++) begin
          val[k] = (16'(grp_bytes[k]) << 2) | 16'((b >> (6 - 2 * k)) & RAW10_LOW_MASK);
        end
        npix = 4;
      end
      MODE_RAW12: begin
        val[0] = (16'(grp_bytes[0]) << 4) | 16'(b >> 4);
        val[1] = (16'(grp_bytes[1]) << 4) | 16'(b & RAW12_LOW_MASK);
        npix = 2;
      end
      default: begin
        val[0] = {b, grp_bytes[0]};
        npix = 1;
      end
    endcase
    last_idx = effective_dim(cur_width) * effective_dim(cur_height) - 1;
    for (int k = 0; k < npix; k++) begin
      eof = (frame_pix_count >= last_idx);
      pix[k] = '{val[k], eof || (k == npix - 1), eof};
      n++;
      if (eof) begin
        frame_pix_count = 0;
        break;
      end
      frame_pix_count++;
    end
    return n;
  endfunction

  // Drops valid and waits until every predicted pixel has been seen, then
  // lets the pipeline drain before anything else is done.
  task automatic wait_idle();
    @(negedge clk_i);
    byte_ch.valid <= 1'b0;
    while (pixels_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Register write; the unit must already be idle.
  task automatic write_reg(input reg_idx_e sel, input logic [DIM_W-1:0] value);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= sel;
    cfg_data <= value;
    case (sel)
      REG_PACKING_MODE: begin
        cur_mode = mode_e'(value[1:0]);
        grp_pos  = '0;
      end
      REG_FRAME_WIDTH:  cur_width  = value;
      REG_FRAME_HEIGHT: cur_height = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Offers one byte after an optional gap and waits for the transaction.
  // Hand-typed pixels, where given, replace the local prediction.
  task automatic feed_byte(input logic [7:0] b, input int n_typed,
                           input logic [15:0] typed_pix [4], input logic typed_eof);
    pixel_t got [4];
    int     n;
    int     gap;
    gap = src_gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.packed_byte <= b;
    do @(posedge clk_i); while (byte_ch.ready !== 1'b1);
    bytes_fed++;
    n = unpack_group(b, got);
    if (n_typed > 0) begin
      for (int k = 0; k < n_typed; k++) begin
        pixels_due.push_back('{typed_pix[k], k == n_typed - 1,
                               typed_eof && (k == n_typed - 1)});
      end
    end else begin
      for (int k = 0; k < n; k++) pixels_due.push_back(got[k]);
    end
  endtask

  // Stimulus: reset, the directed table, then randomised phases.
  initial begin : stimulus
    logic [15:0]      no_typed [4];
    logic [7:0]       b;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    int               random_bytes;
    int               phase;
    int               n_groups;
    int               n_bytes;
    mode_e            m;

    no_typed = '{default: 16'h0};
    random_bytes = 0;
    phase = 0;

    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = '0;
    cfg_data            = '0;
    byte_ch.valid       = 1'b0;
    byte_ch.packed_byte = '0;
    src_gaps_on         = 1'b0;
    sink_stalls_on      = 1'b0;
    mismatches          = 0;
    bytes_fed           = 0;
    pixels_seen         = 0;
    frame_ends          = 0;
    settings_used       = 1;

    // State as it stands after reset.
    cur_mode        = MODE_RAW10;
    cur_width       = DIM_W'(RESET_WIDTH);
    cur_height      = DIM_W'(RESET_HEIGHT);
    grp_pos         = '0;
    grp_bytes       = '{default: 8'h00};
    frame_pix_count = 0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // The directed table runs back to back with no idling on either side.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(directed_rows[i].cfg_sel, directed_rows[i].value);
        settings_used++;
      end else begin
        feed_byte(directed_rows[i].value[7:0], directed_rows[i].n_typed,
                  directed_rows[i].typed_pix, directed_rows[i].typed_eof);
      end
    end

    // Random phases. Each one settles, picks new frame dimensions and mostly
    // a new mode, then streams whole groups of random bytes. Now and then a
    // group is cut short, which shifts the alignment of what follows until
    // the next mode write, and now and then the sender holds off until the
    // unit has drained.
    while (random_bytes < RANDOM_ITEMS) begin
      wait_idle();
      src_gaps_on    = ($urandom_range(0, 2) != 0);
      sink_stalls_on = ($urandom_range(0, 2) != 0);

      case ($urandom_range(0, 7))
        0:       w = '0;
        1:       w = '1;
        2:       w = DIM_W'(MAX_DIMENSION);
        3:       w = DIM_W'($urandom_range(7, 40));
        default: w = DIM_W'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 7))
        0:       h = '0;
        1:       h = '1;
        default: h = DIM_W'($urandom_range(1, 4));
      endcase
      write_reg(REG_FRAME_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, h);
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        m = ($urandom_range(0, 9) == 0) ? MODE_DISCARD : mode_e'($urandom_range(0, 2));
        write_reg(REG_PACKING_MODE, DIM_W'(m));
      end
      settings_used++;

      n_groups = $urandom_range(3, 8);
      for (int g = 0; g < n_groups; g++) begin
        n_bytes = group_bytes(cur_mode);
        if (n_bytes > 1 && $urandom_range(0, 9) == 0) begin
          n_bytes = $urandom_range(1, n_bytes - 1);
        end
        for (int j = 0; j < n_bytes; j++) begin
          if ($urandom_range(0, 7) == 0) begin
            b = $urandom_range(0, 1) ? 8'hff : 8'h00;
          end else begin
            b = 8'($urandom_range(0, 255));
          end
          feed_byte(b, 0, no_typed, 1'b0);
          if (cur_mode != MODE_DISCARD) random_bytes++;
        end
        if ($urandom_range(0, 11) == 0) wait_idle();
      end
      phase++;
    end

    wait_idle();
    $display("Fed %0d bytes over %0d register settings in all four packing modes.",
             bytes_fed, settings_used);
    $display("Checked %0d pixels, %0d of them closing a frame.", pixels_seen, frame_ends);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches found.", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Pixel sink: draws a stall per transaction and checks each pixel against
  // the oldest prediction, field by field.
  initial begin : pixel_sink
    pixel_t due;
    int     stall;
    pixel_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = sink_stalls_on ? $urandom_range(0, MAX_IDLE) : 0;
      @(negedge clk_i);
      if (stall > 0) begin
        pixel_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pixel_ch.ready <= 1'b1;
      do @(posedge clk_i); while (pixel_ch.valid !== 1'b1);
      pixels_seen++;
      if (pixel_ch.end_of_frame === 1'b1) frame_ends++;
      if (pixels_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected pixel, expected none, got value %h last %b eof %b",
                 $time, pixel_ch.pixel_value, pixel_ch.last_of_run,
                 pixel_ch.end_of_frame);
      end else begin
        due = pixels_due.pop_front();
        if (pixel_ch.pixel_value !== due.value) begin
          mismatches++;
          $display("%0t: pixel_value expected %h, got %h",
                   $time, due.value, pixel_ch.pixel_value);
        end
        if (pixel_ch.last_of_run !== due.last) begin
          mismatches++;
          $display("%0t: last_of_run expected %b, got %b",
                   $time, due.last, pixel_ch.last_of_run);
        end
        if (pixel_ch.end_of_frame !== due.eof) begin
          mismatches++;
          $display("%0t: end_of_frame expected %b, got %b",
                   $time, due.eof, pixel_ch.end_of_frame);
        end
      end
    end
  end

  // Watchdog for a unit that stops moving.
  initial begin : watchdog
    #(TIMEOUT_NS * 1ns);
    $display("Timeout at %0t with %0d pixels outstanding.", $time, pixels_due.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
